FILE: src/plucked_string_chord_synth_unit_macros.svh
// assertion macros for the plucked string chord synth unit
`ifndef PLUCKED_STRING_CHORD_SYNTH_UNIT_MACROS_SVH
`define PLUCKED_STRING_CHORD_SYNTH_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PSCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/pscs_pkg.sv
// shared types, codes and voice region tables for the chord synth
package pscs_pkg;

	localparam int ADDR_W   = 10;
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 11;
	localparam int TICK_W   = 11;
	localparam int OUT_W    = 8;
	localparam int SUM_W    = 19;
	localparam int PROD_W   = 31;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;
	localparam logic [GAIN_W-1:0] GAIN_LOW_RESET  = 11'd510;
	localparam logic [GAIN_W-1:0] GAIN_HIGH_RESET = 11'd511;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_RESTART = 2'd1,
		OP_TICK    = 2'd2
	} op_t;

	typedef enum logic {
		REG_GAIN_LOW  = 1'b0,
		REG_GAIN_HIGH = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic restart;
		logic clear_mix;
		logic rd_cur;
		logic rd_nxt;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic voice_active;
	} dp_status_t;

	// first entry of each voice region
	function automatic logic [ADDR_W-1:0] region_lo(input logic [2:0] v);
		logic [ADDR_W-1:0] r;
		unique case (v)
			3'd0: r = 10'd0;
			3'd1: r = 10'd186;
			3'd2: r = 10'd334;
			3'd3: r = 10'd458;
			3'd4: r = 10'd551;
			3'd5: r = 10'd625;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

	// one past the last entry of each voice region
	function automatic logic [ADDR_W-1:0] region_hi(input logic [2:0] v);
		logic [ADDR_W-1:0] r;
		unique case (v)
			3'd0: r = 10'd186;
			3'd1: r = 10'd334;
			3'd2: r = 10'd458;
			3'd3: r = 10'd551;
			3'd4: r = 10'd625;
			3'd5: r = 10'd672;
			default: r = 10'd186;
		endcase
		return r;
	endfunction

endpackage

FILE: src/pscs_ram.sv
// generic simple dual-port ram with registered read
module pscs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 672
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

FILE: src/pscs_ctrl.sv
// controller: walks the voices for a tick and sequences loads, restarts and output
module pscs_ctrl #(
	parameter int VOICES = 6,
	parameter int VIDX_W = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [1:0]           op_code,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output pscs_pkg::ctl_cmd_t   cmd,
	output logic [VIDX_W-1:0]    voice,
	input  pscs_pkg::dp_status_t status
);
	import pscs_pkg::*;

	localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);

	state_t            state_q, state_d;
	logic [VIDX_W-1:0] voice_q, voice_d;
	logic              phase_q, phase_d;
	logic              m_tvalid_q;
	logic              accept;

	assign voice    = voice_q;
	assign m_tvalid = m_tvalid_q;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			voice_q    <= '0;
			phase_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			voice_q <= voice_d;
			phase_q <= phase_d;
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		voice_d  = voice_q;
		phase_d  = phase_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					unique case (op_code)
						OP_LOAD:    cmd.load_wr = 1'b1;
						OP_RESTART: cmd.restart = 1'b1;
						OP_TICK: begin
							cmd.clear_mix = 1'b1;
							voice_d       = '0;
							phase_d       = 1'b0;
							state_d       = ST_RUN;
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				// two read slots per active voice, one idle slot per waiting voice
				if (phase_q) begin
					cmd.rd_nxt = 1'b1;
					phase_d    = 1'b0;
				end else if (status.voice_active) begin
					cmd.rd_cur = 1'b1;
					phase_d    = 1'b1;
				end
				if (phase_q || !status.voice_active) begin
					if (voice_q == LAST_VOICE) begin
						state_d = ST_DRAIN;
					end else begin
						voice_d = voice_q + 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy && (!m_tvalid_q || m_tready)) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

FILE: src/pscs_datapath.sv
// datapath: voice pointers, delay line, filter pipeline, mix and gain registers
module pscs_datapath #(
	parameter int VOICES     = 6,
	parameter int LINE_TOTAL = 672,
	parameter int BLOCK_LEN  = 304,
	parameter int VIDX_W     = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pscs_pkg::ctl_cmd_t                   cmd,
	input  logic [VIDX_W-1:0]                    voice,
	output pscs_pkg::dp_status_t                 status,
	input  logic [pscs_pkg::ADDR_W-1:0]          line_address,
	input  logic signed [pscs_pkg::SAMPLE_W-1:0] line_value,
	input  logic                                 cfg_wr,
	input  logic                                 cfg_sel,
	input  logic [pscs_pkg::GAIN_W-1:0]          cfg_value,
	output logic signed [pscs_pkg::OUT_W-1:0]    audio_sample
);
	import pscs_pkg::*;

	localparam int AW = $clog2(LINE_TOTAL);

	logic [GAIN_W-1:0]   gain_low_q, gain_high_q;
	logic [TICK_W-1:0]   tick_q;
	logic [ADDR_W-1:0]   ptr_q [VOICES];
	logic [SAMPLE_W-1:0] mix_q;
	logic [OUT_W-1:0]    out_q;

	logic [ADDR_W-1:0] cur_ptr, nxt_ptr, inc_ptr;
	logic [11:0]       join_tick;

	logic [SAMPLE_W-1:0] rd_data;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [SAMPLE_W-1:0] wr_data;
	logic                wr_en;

	// pipeline: s1 cur read issued, s2 cur held, s3 filter sum, s4 gain product
	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic [VIDX_W-1:0]         voice_s1, voice_s2, voice_s3;
	logic [ADDR_W-1:0]         addr_s1, addr_s2, addr_s3, addr_s4;
	logic signed [SAMPLE_W-1:0] cur_s2;
	logic signed [SUM_W-1:0]   sum_s3;
	logic signed [PROD_W-1:0]  prod_s4;

	logic signed [SUM_W-1:0]  cur_x, nxt_x, sum_d;
	logic [GAIN_W-1:0]        gain_sel;
	logic signed [PROD_W-1:0] rounded;

	assign cur_ptr = ptr_q[voice];
	assign inc_ptr = cur_ptr + 1'b1;
	assign nxt_ptr = (inc_ptr == region_hi(3'(voice))) ? region_lo(3'(voice)) : inc_ptr;
	assign join_tick = 12'(int'(voice) * BLOCK_LEN);

	assign status.voice_active = {1'b0, tick_q} >= join_tick;
	assign status.pipe_busy    = valid_s1 || valid_s2 || valid_s3 || valid_s4;
	assign audio_sample        = out_q;

	assign rd_addr = cmd.rd_nxt ? AW'(nxt_ptr) : AW'(cur_ptr);

	pscs_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (LINE_TOTAL)
	) u_line (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// filter sum: voice zero weights the next entry by three, the rest the current one
	assign cur_x = SUM_W'(cur_s2);
	assign nxt_x = SUM_W'($signed(rd_data));
	assign sum_d = (voice_s2 == '0) ? (cur_x + (nxt_x <<< 1) + nxt_x + SUM_W'(2))
	                                : ((cur_x <<< 1) + cur_x + nxt_x + SUM_W'(2));

	assign gain_sel = (int'(voice_s3) >= 4) ? gain_high_q : gain_low_q;

	// divide by 2048 truncating toward zero
	assign rounded = prod_s4 + (prod_s4[PROD_W-1] ? PROD_W'(2047) : PROD_W'(0));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(addr_s4);
		wr_data = rounded[SAMPLE_W+10:11];
		if (valid_s4) begin
			wr_en = 1'b1;
		end else if (cmd.load_wr && (int'(line_address) < LINE_TOTAL)) begin
			wr_en   = 1'b1;
			wr_addr = AW'(line_address);
			wr_data = line_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_low_q  <= GAIN_LOW_RESET;
			gain_high_q <= GAIN_HIGH_RESET;
			tick_q      <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			for (int i = 0; i < VOICES; i++) begin
				ptr_q[i] <= region_lo(3'(i));
			end
		end else begin
			if (cfg_wr) begin
				unique case (cfg_reg_t'(cfg_sel))
					REG_GAIN_LOW:  gain_low_q  <= cfg_value;
					REG_GAIN_HIGH: gain_high_q <= cfg_value;
					default: ;
				endcase
			end
			valid_s1 <= cmd.rd_cur;
			valid_s2 <= cmd.rd_nxt;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (cmd.restart) begin
				tick_q <= '0;
				for (int i = 0; i < VOICES; i++) begin
					ptr_q[i] <= region_lo(3'(i));
				end
			end else begin
				if (cmd.rd_nxt) begin
					ptr_q[voice] <= nxt_ptr;
				end
				if (cmd.finish && tick_q != TICK_MAX) begin
					tick_q <= tick_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_cur) begin
			voice_s1 <= voice;
			addr_s1  <= cur_ptr;
		end
		if (cmd.rd_nxt) begin
			voice_s2 <= voice_s1;
			addr_s2  <= addr_s1;
			cur_s2   <= $signed(rd_data);
		end
		voice_s3 <= voice_s2;
		addr_s3  <= addr_s2;
		sum_s3   <= sum_d;
		addr_s4  <= addr_s3;
		prod_s4  <= PROD_W'(sum_s3 * $signed({1'b0, gain_sel}));
		if (cmd.clear_mix) begin
			mix_q <= '0;
		end else if (cmd.rd_nxt) begin
			mix_q <= mix_q + rd_data;
		end
		if (cmd.finish) begin
			out_q <= mix_q[SAMPLE_W-1:SAMPLE_W-OUT_W];
		end
	end
endmodule

FILE: src/plucked_string_chord_synth_unit.sv
// top level of the six-voice plucked string chord synthesizer
// load and restart words are taken in idle; a tick word is accepted in idle, then each sounding
// voice gets a current and a next read on the single ram read port, each waiting voice an idle
// slot, and the tick finishes once the filter pipeline has drained and the output slot is free
// a new word is accepted only in idle, so not before the previous tick has finished
// reset (arst_n low, asynchronous) rewinds the voice pointers, clears the tick count, gains 510/511
`include "plucked_string_chord_synth_unit_macros.svh"

module plucked_string_chord_synth_unit #(
	parameter int VOICES     = 6,
	parameter int LINE_TOTAL = 672,
	parameter int BLOCK_LEN  = 304
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // line_address[9:0], line_value[25:10], zero[31:26]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // audio_sample[7:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import pscs_pkg::*;

	localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

	ctl_cmd_t          cmd;
	dp_status_t        status;
	logic [VIDX_W-1:0] voice;
	logic signed [OUT_W-1:0] audio_sample;

	assign cfg_ready = 1'b1;
	assign m_tdata   = audio_sample;

	pscs_ctrl #(
		.VOICES (VOICES),
		.VIDX_W (VIDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op_code  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.voice    (voice),
		.status   (status)
	);

	pscs_datapath #(
		.VOICES     (VOICES),
		.LINE_TOTAL (LINE_TOTAL),
		.BLOCK_LEN  (BLOCK_LEN),
		.VIDX_W     (VIDX_W)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.voice        (voice),
		.status       (status),
		.line_address (s_tdata[9:0]),
		.line_value   ($signed(s_tdata[25:10])),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_sel      (cfg_index),
		.cfg_value    (cfg_data),
		.audio_sample (audio_sample)
	);

	`PSCS_ASSERT_NOW(a_ready_when_drained, clk, arst_n, s_tready, !status.pipe_busy, "word taken while filter pipeline busy")
	`PSCS_ASSERT_NEXT(a_cur_then_nxt, clk, arst_n, cmd.rd_cur, cmd.rd_nxt, "current read not followed by next read")
	`PSCS_ASSERT_NOW(a_one_command, clk, arst_n, 1'b1, $onehot0({cmd.load_wr, cmd.restart, cmd.rd_cur, cmd.rd_nxt, cmd.finish}), "conflicting datapath commands")
	`PSCS_ASSERT_NOW(a_finish_slot_free, clk, arst_n, cmd.finish, !status.pipe_busy && (!m_tvalid || m_tready), "sample finished over a waiting one")

endmodule
